// ===== design/linear_probe_hash_table_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the linear probe hash table
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH

// Property checked on every clock edge outside of reset.
`define LPHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property that must also hold while reset is applied.
`define LPHT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/lpht_pkg.sv =====
// ----------------------------------------------------------------------------
// Linear probe hash table package
// Sizes, operation and status codes, and the types shared between modules.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int SLOTS  = 256;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int KEY_W  = 31;
  localparam int IDX_W  = 8;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] STAT_DONE = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  // Occupancy threshold: count * 4 >= SLOTS * 3.
  localparam logic [CNT_W+1:0] LOAD_LIMIT = (CNT_W + 2)'(SLOTS * 3);

  typedef struct packed {
    logic [1:0]       opcode;
    logic [KEY_W-1:0] key;
  } in_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] slot_index;
    logic             load_high;
  } out_res_t;

  typedef struct packed {
    logic       load;
    logic       advance;
    logic       ins_write;
    logic       rem_clear;
    logic       res_we;
    logic [1:0] res_status;
    logic       res_hit;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       slot_used;
    logic       key_match;
    logic       last_probe;
  } dp_stat_t;

endpackage

// ===== design/lpht_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/lpht_dp.sv =====
// ----------------------------------------------------------------------------
// Linear probe hash table datapath
// Key store, slot valid bits, probe pointer, occupancy count and result.
// ----------------------------------------------------------------------------
module lpht_dp import lpht_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  in_req_t  in_req,
  input  ctl_cmd_t cmd,
  output dp_stat_t stat,
  output out_res_t out_res
);

  logic [1:0]       op_r;
  logic [KEY_W-1:0] key_r;
  logic [SLOT_W-1:0] s_r, s_nxt;
  logic [SLOT_W-1:0] n_r, n_nxt;
  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [1:0]       res_status_r;
  logic [IDX_W-1:0] res_slot_r;
  logic [KEY_W-1:0] ram_rdata;

  lpht_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_key_store (
    .clk   (clk),
    .we    (cmd.ins_write),
    .waddr (s_r),
    .wdata (key_r),
    .raddr (s_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    s_nxt     = s_r;
    n_nxt     = n_r;
    valid_nxt = valid_r;
    count_nxt = count_r;
    if (cmd.load) begin
      s_nxt = in_req.key[SLOT_W-1:0];
      n_nxt = '0;
    end else if (cmd.advance) begin
      s_nxt = s_r + 1'b1;
      n_nxt = n_r + 1'b1;
    end
    if (cmd.ins_write) begin
      valid_nxt[s_r] = 1'b1;
      count_nxt      = count_r + 1'b1;
    end else if (cmd.rem_clear) begin
      valid_nxt[s_r] = 1'b0;
      if (count_r != '0) begin
        count_nxt = count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r <= s_nxt;
    n_r <= n_nxt;
    if (cmd.load) begin
      op_r  <= in_req.opcode;
      key_r <= in_req.key;
    end
    if (cmd.res_we) begin
      res_status_r <= cmd.res_status;
      res_slot_r   <= cmd.res_hit ? IDX_W'(s_r) : '0;
    end
  end

  assign stat.opcode     = op_r;
  assign stat.slot_used  = valid_r[s_r];
  assign stat.key_match  = (ram_rdata == key_r);
  assign stat.last_probe = (n_r == SLOT_W'(SLOTS - 1));

  assign out_res.status     = res_status_r;
  assign out_res.slot_index = res_slot_r;
  assign out_res.load_high  = ({count_r, 2'b00} >= LOAD_LIMIT);

endmodule

// ===== design/lpht_ctrl.sv =====
// ----------------------------------------------------------------------------
// Linear probe hash table controller
// Sequences the probe loop and issues commands to the datapath.
// ----------------------------------------------------------------------------
module lpht_ctrl import lpht_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd,
  output logic     busy,
  output logic     out_valid
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PROBE = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        // The key store read for the current slot is issued here.
        if (stat.opcode != OP_INSERT && stat.opcode != OP_SEARCH &&
            stat.opcode != OP_REMOVE) begin
          cmd.res_we     = 1'b1;
          cmd.res_status = STAT_MISS;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.opcode == OP_INSERT) begin
          if (!stat.slot_used) begin
            cmd.ins_write  = 1'b1;
            cmd.res_we     = 1'b1;
            cmd.res_status = STAT_DONE;
            cmd.res_hit    = 1'b1;
            state_nxt      = S_DONE;
          end else if (stat.last_probe) begin
            cmd.res_we     = 1'b1;
            cmd.res_status = STAT_FULL;
            state_nxt      = S_DONE;
          end else begin
            cmd.advance = 1'b1;
            state_nxt   = S_PROBE;
          end
        end else begin
          if (!stat.slot_used || (!stat.key_match && stat.last_probe)) begin
            cmd.res_we     = 1'b1;
            cmd.res_status = STAT_MISS;
            state_nxt      = S_DONE;
          end else if (stat.key_match) begin
            cmd.rem_clear  = (stat.opcode == OP_REMOVE);
            cmd.res_we     = 1'b1;
            cmd.res_status = STAT_DONE;
            cmd.res_hit    = 1'b1;
            state_nxt      = S_DONE;
          end else begin
            cmd.advance = 1'b1;
            state_nxt   = S_PROBE;
          end
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

endmodule

// ===== design/linear_probe_hash_table.sv =====
// ----------------------------------------------------------------------------
// Linear probe hash table
// Open-addressing key table of SLOTS entries with forward linear probing.
// ----------------------------------------------------------------------------
// Usage: a request (opcode and key on in_req) is taken at a rising edge where
// start is high and busy is low. Busy stays high until the result has been
// shown, so one request is in flight at a time.
// The result (status, slot index, load flag on out_res) is present for exactly
// one cycle, marked by out_valid; the receiver cannot stall it, so it must
// capture the result in that cycle.
// Timing: each probed slot passes through S_PROBE, which reads the key store
// RAM, and then S_CHECK, which compares and decides. A request that resolves
// on a probe moves to S_DONE, which raises out_valid, and is then idle again;
// at most a full lap over all slots is probed before the request resolves.
// The unused opcode goes from S_PROBE straight to S_DONE without a compare.
// The probe rate is set by the single registered read port of the key store.
// Reset: synchronous, active low. All slots become empty at once through a
// bank of valid bits, and the occupancy count returns to zero; the key store
// RAM itself is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module linear_probe_hash_table import lpht_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  in_req_t  in_req,
  output logic     busy,
  output logic     out_valid,
  output out_res_t out_res
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // The controller owns the probe sequence and the handshake.
  lpht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // The datapath holds the table and the result register.
  lpht_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .cmd     (cmd),
    .stat    (stat),
    .out_res (out_res)
  );

endmodule

// ===== design/lpht_checker.sv =====
// ----------------------------------------------------------------------------
// Linear probe hash table checker
// Port-level assertions on the request and result sequencing.
// ----------------------------------------------------------------------------
`include "linear_probe_hash_table_defines.svh"

module lpht_checker import lpht_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input out_res_t out_res
);

  `LPHT_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted request did not raise busy")
  `LPHT_ASSERT(a_result_in_flight, out_valid |-> busy, "result strobe without a request")
  `LPHT_ASSERT(a_result_once, out_valid |=> (!out_valid && !busy), "result not single cycle")
  `LPHT_ASSERT(a_miss_slot_zero, (out_valid && out_res.status != STAT_DONE) |-> (out_res.slot_index == '0), "slot index nonzero on miss")
  `LPHT_ASSERT_RST(a_reset_idle, !rst_n |=> (!busy && !out_valid), "block not idle after reset")

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (.*);
